@@ hdl/arpc_pkg.sv @@
package arpc_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register indexes, decoded from paddr[3:2]
    localparam logic [1:0] REG_LOCAL_IP        = 2'd0;
    localparam logic [1:0] REG_VALID_TIMEOUT   = 2'd1;
    localparam logic [1:0] REG_PENDING_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_RETRY_LIMIT     = 2'd3;

    // request types
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_PACKET  = 2'd1;
    localparam logic [1:0] REQ_RESOLVE = 2'd2;

    // send kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_REPLY   = 2'd2;

    // header values of an Ethernet/IPv4 ARP packet
    localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
    localparam logic [15:0] PROTO_IPV4     = 16'h0800;
    localparam logic [7:0]  HW_LEN_ETH     = 8'd6;
    localparam logic [7:0]  PROTO_LEN_IPV4 = 8'd4;
    localparam logic [15:0] OP_REQUEST     = 16'd1;
    localparam logic [15:0] OP_REPLY       = 16'd2;

    localparam logic [31:0] RST_LOCAL_IP        = 32'd0;
    localparam logic [15:0] RST_VALID_TIMEOUT   = 16'd5;
    localparam logic [15:0] RST_PENDING_TIMEOUT = 16'd1;
    localparam logic [7:0]  RST_RETRY_LIMIT     = 8'd4;

    typedef enum logic [1:0] {
        ST_FREE      = 2'd0,
        ST_VALID     = 2'd1,
        ST_RESOLVING = 2'd2
    } entry_state_t;

    typedef struct packed {
        logic [31:0] local_ip;
        logic [15:0] valid_timeout;
        logic [15:0] pending_timeout;
        logic [7:0]  retry_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        frame_long_enough;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] opcode;
        logic [31:0] src_ip;
        logic [47:0] src_mac;
        logic [31:0] dst_ip;
        logic [31:0] lookup_ip;
    } item_t;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [31:0] send_ip;
        logic [47:0] send_mac;
        logic        hit;
        logic [47:0] hit_mac;
        logic [1:0]  entry_status;
    } result_t;

endpackage

@@ hdl/arp_single_entry_cache.sv @@
// Single-entry ARP cache.
// Item channel (item_valid/item_ready/item): one event per transfer, a timer
// tick, a received ARP header or a resolve query, selected by req_type.
// Result channel (result_valid/result_ready/result): exactly one result per
// event, in order, carrying any request or reply to send, the lookup hit and
// the entry status after the event.
// The event is held in an input register; the entry update and result are
// computed in one pass and land in the result register.
// Throughput is one event per cycle while results are taken; the single
// entry update is the only loop and it closes within that pass.
// When the receiver stalls, the result register holds and one more event
// waits in the input register; item_ready drops only when both are full.
// Reset frees the entry, clears its fields and loads the register defaults
// (local_ip 0, valid_timeout 5, pending_timeout 1, retry_limit 4).
// Write configuration over the APB port only while no event is in flight.
module arp_single_entry_cache
    import arpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  item_t             item,
    output logic              result_valid,
    input  logic              result_ready,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;

    arpc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    arpc_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

@@ hdl/arpc_cfg_regs.sv @@
module arpc_cfg_regs
    import arpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_ip        <= RST_LOCAL_IP;
            cfg_reg.valid_timeout   <= RST_VALID_TIMEOUT;
            cfg_reg.pending_timeout <= RST_PENDING_TIMEOUT;
            cfg_reg.retry_limit     <= RST_RETRY_LIMIT;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_LOCAL_IP:        cfg_reg.local_ip        <= pwdata;
                REG_VALID_TIMEOUT:   cfg_reg.valid_timeout   <= pwdata[15:0];
                REG_PENDING_TIMEOUT: cfg_reg.pending_timeout <= pwdata[15:0];
                REG_RETRY_LIMIT:     cfg_reg.retry_limit     <= pwdata[7:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LOCAL_IP:        prdata = cfg_reg.local_ip;
            REG_VALID_TIMEOUT:   prdata = {16'd0, cfg_reg.valid_timeout};
            REG_PENDING_TIMEOUT: prdata = {16'd0, cfg_reg.pending_timeout};
            REG_RETRY_LIMIT:     prdata = {24'd0, cfg_reg.retry_limit};
            default:             prdata = '0;
        endcase
    end

endmodule

@@ hdl/arpc_engine.sv @@
module arpc_engine
    import arpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    logic         in_valid_reg;
    item_t        in_item_reg;
    logic         out_valid_reg;
    result_t      out_reg;
    result_t      out_next;

    entry_state_t entry_state_reg, entry_state_next;
    logic [31:0]  entry_ip_reg, entry_ip_next;
    logic [47:0]  entry_mac_reg, entry_mac_next;
    logic [15:0]  countdown_reg, countdown_next;
    logic [7:0]   retries_reg, retries_next;

    logic         advance;
    logic [15:0]  cd_dec;
    logic         pkt_ok;
    logic         lookup_hit;

    // advance the input stage whenever the result slot is free or being taken
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign cd_dec = countdown_reg - 16'd1;

    assign pkt_ok = in_item_reg.frame_long_enough
                 && in_item_reg.hw_type == HW_TYPE_ETH
                 && in_item_reg.proto_type == PROTO_IPV4
                 && in_item_reg.hw_len == HW_LEN_ETH
                 && in_item_reg.proto_len == PROTO_LEN_IPV4
                 && (in_item_reg.opcode == OP_REQUEST || in_item_reg.opcode == OP_REPLY)
                 && in_item_reg.dst_ip == cfg.local_ip;

    assign lookup_hit = entry_state_reg == ST_VALID && entry_ip_reg == in_item_reg.lookup_ip;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
                in_valid_reg <= item_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            in_item_reg <= item;
        if (advance)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_state_reg <= ST_FREE;
            entry_ip_reg    <= '0;
            entry_mac_reg   <= '0;
            countdown_reg   <= '0;
            retries_reg     <= '0;
        end
        else if (advance)
        begin
            entry_state_reg <= entry_state_next;
            entry_ip_reg    <= entry_ip_next;
            entry_mac_reg   <= entry_mac_next;
            countdown_reg   <= countdown_next;
            retries_reg     <= retries_next;
        end
    end

    always_comb
    begin
        entry_state_next = entry_state_reg;
        entry_ip_next    = entry_ip_reg;
        entry_mac_next   = entry_mac_reg;
        countdown_next   = countdown_reg;
        retries_next     = retries_reg;
        out_next         = '0;

        case (in_item_reg.req_type)
            REQ_TICK:
            begin
                unique case (entry_state_reg)
                    ST_VALID:
                    begin
                        countdown_next = cd_dec;
                        if (cd_dec == 16'd0)
                        begin
                            out_next.send_kind = KIND_REQUEST;
                            out_next.send_ip   = entry_ip_reg;
                            entry_state_next   = ST_RESOLVING;
                            countdown_next     = cfg.pending_timeout;
                        end
                    end
                    ST_RESOLVING:
                    begin
                        countdown_next = cd_dec;
                        if (cd_dec == 16'd0)
                        begin
                            // free the entry once the retries are used up
                            if (retries_reg == 8'd0)
                                entry_state_next = ST_FREE;
                            else
                            begin
                                retries_next       = retries_reg - 8'd1;
                                out_next.send_kind = KIND_REQUEST;
                                out_next.send_ip   = entry_ip_reg;
                                countdown_next     = cfg.pending_timeout;
                            end
                        end
                    end
                    ST_FREE: ;
                    default: ;
                endcase
            end
            REQ_PACKET:
            begin
                if (pkt_ok)
                begin
                    if (in_item_reg.opcode == OP_REQUEST)
                    begin
                        out_next.send_kind = KIND_REPLY;
                        out_next.send_ip   = in_item_reg.src_ip;
                        out_next.send_mac  = in_item_reg.src_mac;
                    end
                    entry_ip_next    = in_item_reg.src_ip;
                    entry_mac_next   = in_item_reg.src_mac;
                    entry_state_next = ST_VALID;
                    countdown_next   = cfg.valid_timeout;
                    retries_next     = cfg.retry_limit;
                end
            end
            REQ_RESOLVE:
            begin
                if (lookup_hit)
                begin
                    out_next.hit     = 1'b1;
                    out_next.hit_mac = entry_mac_reg;
                end
                else
                begin
                    out_next.send_kind = KIND_REQUEST;
                    out_next.send_ip   = in_item_reg.lookup_ip;
                end
            end
            default: ;
        endcase

        out_next.entry_status = entry_state_next;
    end

    a_hit_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.hit |-> out_reg.entry_status == ST_VALID)
        else $error("hit reported on an entry that is not valid");

    a_hit_no_send: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.hit |-> out_reg.send_kind == KIND_NONE)
        else $error("hit and send request in the same result");

    a_reply_refreshes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.send_kind == KIND_REPLY |-> out_reg.entry_status == ST_VALID)
        else $error("reply sent without a refreshed entry");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> in_valid_reg && out_valid_reg && !result_ready)
        else $error("input stalled while a stage is free");

    a_state_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_reg.entry_status == entry_state_reg)
        else $error("reported status differs from the stored entry");

endmodule
